### design/pvdw_pkg.sv
`default_nettype none
package pvdw_pkg;

    localparam logic [20:0] DRAG_K_Q32 = 21'd1210107;
    localparam int          GRAVITY_PX = 9800;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    typedef enum logic [2:0] {
        CFG_RADIUS,
        CFG_MASS,
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_START_X,
        CFG_START_Y,
        CFG_START_VX,
        CFG_START_VY
    } t_cfg_idx;

    typedef enum logic [2:0] {
        HIT_NONE,
        HIT_TOP,
        HIT_RIGHT,
        HIT_BOTTOM,
        HIT_LEFT
    } t_hit;

endpackage
`default_nettype wire

### design/particle_verlet_drag_wall_step_core.sv
`default_nettype none
// Disc stepper, velocity Verlet with gravity, air drag and wall bounce. Each dt transfer runs
// one tick: drag from |v| (square root) and mass (divide), position and velocity update,
// clamp to the top and right walls and reflection at the first wall hit. All multiplies,
// divides and square roots run through one shared shift-add multiply / restoring divide /
// square root unit: 12 multiplies of 32 iterations, one square root of 32 and two divides of 64.
// A finished result waits in the output register until taken; a tick that ends while the
// register is still full stalls before its last step. dt is taken only between ticks.
// Config writes take effect at once; start writes also load the disc state.
module particle_verlet_drag_wall_step_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_dt_valid,
    output logic             o_dt_ready,
    input  wire logic [15:0] i_dt,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic [2:0]       o_wall_hit
);
    import pvdw_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int XW = 72;
    localparam logic signed [XW-1:0] WMAX   = (72'sd1 <<< (W - 1)) - 72'sd1;
    localparam logic signed [XW-1:0] WMIN   = -WMAX - 72'sd1;
    localparam logic signed [XW-1:0] S32MAX = 72'sd2147483647;
    localparam logic signed [XW-1:0] S32MIN = -72'sd2147483648;

    typedef enum logic [4:0] {
        S_IDLE, S_DT2, S_SQX, S_SQY, S_SQRT, S_T2, S_T3X, S_DVX, S_T3Y, S_DVY,
        S_PVX, S_PAX, S_PVY, S_PAY, S_AVG, S_VX, S_VY, S_WALL, S_FIN
    } t_state;

    function automatic logic signed [XW-1:0] sx(input logic signed [W-1:0] v);
        return XW'(v);
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
        if (v > WMAX) return W'(WMAX);
        else if (v < WMIN) return W'(WMIN);
        else return W'(v);
    endfunction

    function automatic logic [63:0] mag64(input logic signed [W-1:0] v);
        logic signed [XW-1:0] e;
        e = sx(v);
        return (e < 0) ? 64'(-e) : 64'(e);
    endfunction

    function automatic logic [30:0] clamp31(input logic signed [W-1:0] v);
        logic [63:0] m;
        m = mag64(v);
        return (m > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : m[30:0];
    endfunction

    function automatic logic signed [XW-1:0] apply(input logic [XW-1:0] m, input logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [W-1:0] v);
        logic signed [XW-1:0] e;
        e = sx(v);
        if (e > S32MAX) return 32'h7FFF_FFFF;
        else if (e < S32MIN) return 32'h8000_0000;
        else return e[31:0];
    endfunction

    t_state r_state;
    logic   r_wait;

    logic [9:0]  r_radius;
    logic [15:0] r_mass;
    logic [13:0] r_width;
    logic [13:0] r_height;

    logic signed [W-1:0] r_px, r_py, r_vx, r_vy, r_ax, r_ay, r_nax, r_nay;
    logic [15:0] r_dt;
    logic [15:0] r_dt2;
    logic [63:0] r_sum;
    logic [31:0] r_speed;
    logic [30:0] r_t2;
    logic [63:0] r_num;
    logic signed [XW-1:0] r_tmp;
    t_hit r_hit;

    logic        r_out_valid;
    logic [31:0] r_out_px, r_out_py, r_out_vx, r_out_vy;
    t_hit        r_out_hit;

    t_alu_ctl    alu_ctl;
    logic [63:0] alu_a;
    logic [31:0] alu_b;
    logic        alu_done;
    logic [95:0] alu_res;

    logic [30:0] mx, my, t1;
    logic [15:0] mass_eff;
    logic signed [W-1:0] xlim, ylim, rlim, c_grav;
    logic signed [XW-1:0] sm16, sm17;

    pvdw_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (alu_ctl),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    always_comb begin
        mx       = clamp31(r_vx);
        my       = clamp31(r_vy);
        t1       = 31'({10'b0, DRAG_K_Q32} * {21'b0, r_radius});
        mass_eff = (r_mass == 16'd0) ? 16'd1 : r_mass;
        xlim     = sat_w(($signed({58'b0, r_width}) - $signed({62'b0, r_radius}))
                         <<< FRAC_BITS);
        ylim     = sat_w(($signed({58'b0, r_height}) - $signed({62'b0, r_radius}))
                         <<< FRAC_BITS);
        rlim     = sat_w($signed({62'b0, r_radius}) <<< FRAC_BITS);
        c_grav   = sat_w(-(72'sd9800 <<< FRAC_BITS));
        sm16     = $signed(XW'(alu_res >> 16));
        sm17     = $signed(XW'(alu_res >> 17));
    end

    always_comb begin
        alu_ctl.op    = ALU_MUL;
        alu_ctl.start = 1'b0;
        alu_a         = '0;
        alu_b         = '0;
        unique case (r_state)
            S_DT2:  begin alu_ctl.start = 1'b1; alu_a = {48'b0, r_dt}; alu_b = {16'b0, r_dt}; end
            S_SQX:  begin alu_ctl.start = 1'b1; alu_a = {33'b0, mx}; alu_b = {1'b0, mx}; end
            S_SQY:  begin alu_ctl.start = 1'b1; alu_a = {33'b0, my}; alu_b = {1'b0, my}; end
            S_SQRT: begin alu_ctl.start = 1'b1; alu_ctl.op = ALU_SQRT; alu_a = r_sum; end
            S_T2:   begin alu_ctl.start = 1'b1; alu_a = {33'b0, t1}; alu_b = r_speed; end
            S_T3X:  begin alu_ctl.start = 1'b1; alu_a = {33'b0, r_t2}; alu_b = {1'b0, mx}; end
            S_T3Y:  begin alu_ctl.start = 1'b1; alu_a = {33'b0, r_t2}; alu_b = {1'b0, my}; end
            S_DVX, S_DVY: begin
                alu_ctl.start = 1'b1;
                alu_ctl.op    = ALU_DIV;
                alu_a         = r_num;
                alu_b         = {16'b0, mass_eff};
            end
            S_PVX:  begin alu_ctl.start = 1'b1; alu_a = mag64(r_vx); alu_b = {16'b0, r_dt}; end
            S_PAX:  begin alu_ctl.start = 1'b1; alu_a = mag64(r_ax); alu_b = {16'b0, r_dt2}; end
            S_PVY:  begin alu_ctl.start = 1'b1; alu_a = mag64(r_vy); alu_b = {16'b0, r_dt}; end
            S_PAY:  begin alu_ctl.start = 1'b1; alu_a = mag64(r_ay); alu_b = {16'b0, r_dt2}; end
            S_VX:   begin alu_ctl.start = 1'b1; alu_a = mag64(r_ax); alu_b = {16'b0, r_dt}; end
            S_VY:   begin alu_ctl.start = 1'b1; alu_a = mag64(r_ay); alu_b = {16'b0, r_dt}; end
            default: begin
                alu_ctl.start = 1'b0;
            end
        endcase
        alu_ctl.start = alu_ctl.start && !r_wait;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_radius    <= 10'd10;
            r_mass      <= 16'd256;
            r_width     <= 14'd1024;
            r_height    <= 14'd768;
            r_px        <= '0;
            r_py        <= '0;
            r_vx        <= '0;
            r_vy        <= '0;
            r_ax        <= '0;
            r_ay        <= '0;
        end else begin
            if (r_out_valid && i_res_ready && (r_state != S_FIN)) r_out_valid <= 1'b0;
            if (alu_ctl.start) r_wait <= 1'b1;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_RADIUS:   r_radius <= i_cfg_data[9:0];
                    CFG_MASS:     r_mass   <= i_cfg_data[15:0];
                    CFG_WIDTH:    r_width  <= i_cfg_data[13:0];
                    CFG_HEIGHT:   r_height <= i_cfg_data[13:0];
                    CFG_START_X:  r_px     <= sat_w(XW'($signed(i_cfg_data)));
                    CFG_START_Y:  r_py     <= sat_w(XW'($signed(i_cfg_data)));
                    CFG_START_VX: r_vx     <= sat_w(XW'($signed(i_cfg_data)));
                    CFG_START_VY: r_vy     <= sat_w(XW'($signed(i_cfg_data)));
                    default:      r_radius <= r_radius;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_dt_valid) begin
                        r_dt    <= i_dt;
                        r_state <= S_DT2;
                    end
                end
                S_AVG: begin
                    r_ax    <= W'((sx(r_ax) + sx(r_nax)) >>> 1);
                    r_ay    <= W'((sx(r_ay) + sx(r_nay)) >>> 1);
                    r_state <= S_VX;
                end
                S_WALL: begin
                    r_state <= S_FIN;
                    if (r_py >= ylim) begin
                        r_vy  <= sat_w(-sx(r_vy));
                        r_hit <= HIT_TOP;
                    end else if (r_px >= xlim) begin
                        r_vx  <= sat_w(-sx(r_vx));
                        r_hit <= HIT_RIGHT;
                    end else if (r_py <= rlim) begin
                        r_vy  <= sat_w(-sx(r_vy));
                        r_hit <= HIT_BOTTOM;
                    end else if (r_px <= rlim) begin
                        r_vx  <= sat_w(-sx(r_vx));
                        r_hit <= HIT_LEFT;
                    end else begin
                        r_hit <= HIT_NONE;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_res_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_px    <= sat32(r_px);
                        r_out_py    <= sat32(r_py);
                        r_out_vx    <= sat32(r_vx);
                        r_out_vy    <= sat32(r_vy);
                        r_out_hit   <= r_hit;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    if (alu_done) begin
                        r_wait <= 1'b0;
                        unique case (r_state)
                            S_DT2: begin r_dt2 <= alu_res[31:16]; r_state <= S_SQX; end
                            S_SQX: begin r_sum <= alu_res[63:0]; r_state <= S_SQY; end
                            S_SQY: begin r_sum <= r_sum + alu_res[63:0]; r_state <= S_SQRT; end
                            S_SQRT: begin r_speed <= alu_res[31:0]; r_state <= S_T2; end
                            S_T2: begin r_t2 <= alu_res[62:32]; r_state <= S_T3X; end
                            S_T3X: begin
                                r_num   <= 64'(alu_res >> FRAC_BITS) << 8;
                                r_state <= S_DVX;
                            end
                            S_DVX: begin
                                r_nax   <= sat_w(apply(XW'(alu_res[63:0]), r_vx > 0));
                                r_state <= S_T3Y;
                            end
                            S_T3Y: begin
                                r_num   <= 64'(alu_res >> FRAC_BITS) << 8;
                                r_state <= S_DVY;
                            end
                            S_DVY: begin
                                r_nay   <= sat_w(apply(XW'(alu_res[63:0]), r_vy > 0)
                                                 + sx(c_grav));
                                r_state <= S_PVX;
                            end
                            S_PVX: begin r_tmp <= apply(sm16, r_vx < 0); r_state <= S_PAX; end
                            S_PAX: begin
                                if (sat_w(sx(r_px) + r_tmp + apply(sm17, r_ax < 0)) > xlim)
                                    r_px <= xlim;
                                else
                                    r_px <= sat_w(sx(r_px) + r_tmp + apply(sm17, r_ax < 0));
                                r_state <= S_PVY;
                            end
                            S_PVY: begin r_tmp <= apply(sm16, r_vy < 0); r_state <= S_PAY; end
                            S_PAY: begin
                                if (sat_w(sx(r_py) + r_tmp + apply(sm17, r_ay < 0)) > ylim)
                                    r_py <= ylim;
                                else
                                    r_py <= sat_w(sx(r_py) + r_tmp + apply(sm17, r_ay < 0));
                                r_state <= S_AVG;
                            end
                            S_VX: begin
                                r_vx    <= sat_w(sx(r_vx) + apply(sm16, r_ax < 0));
                                r_state <= S_VY;
                            end
                            S_VY: begin
                                r_vy    <= sat_w(sx(r_vy) + apply(sm16, r_ay < 0));
                                r_state <= S_WALL;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

    assign o_dt_ready  = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_pos_x     = r_out_px;
    assign o_pos_y     = r_out_py;
    assign o_vel_x     = r_out_vx;
    assign o_vel_y     = r_out_vy;
    assign o_wall_hit  = r_out_hit;

endmodule
`default_nettype wire

### design/pvdw_alu.sv
`default_nettype none
module pvdw_alu (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pvdw_pkg::t_alu_ctl i_ctl,
    input  wire logic [63:0]      i_a,
    input  wire logic [31:0]      i_b,
    output logic                  o_done,
    output logic [95:0]           o_res
);
    import pvdw_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_alu_op     r_op;
    logic [6:0]  r_cnt;
    logic [95:0] r_acc;
    logic [95:0] r_mc;
    logic [63:0] r_y;
    logic [63:0] r_q;
    logic [34:0] r_rem;
    logic [15:0] r_dv;

    logic [16:0] n_dtry;
    logic        n_dge;
    logic [34:0] n_stry;
    logic [34:0] n_strial;
    logic        n_sge;

    always_comb begin
        n_dtry   = {r_rem[15:0], r_y[63]};
        n_dge    = (n_dtry >= {1'b0, r_dv});
        n_stry   = {r_rem[32:0], r_y[63:62]};
        n_strial = {1'b0, r_q[31:0], 2'b01};
        n_sge    = (n_stry >= n_strial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_acc  <= '0;
                r_mc   <= {32'b0, i_a};
                r_y    <= (i_ctl.op == ALU_MUL) ? {32'b0, i_b} : i_a;
                r_dv   <= i_b[15:0];
                r_q    <= '0;
                r_rem  <= '0;
                r_cnt  <= (i_ctl.op == ALU_DIV) ? 7'd64 : 7'd32;
            end else if (r_busy) begin
                unique case (r_op)
                    ALU_MUL: begin
                        if (r_y[0]) r_acc <= r_acc + r_mc;
                        r_mc <= r_mc << 1;
                        r_y  <= r_y >> 1;
                    end
                    ALU_DIV: begin
                        r_rem <= {18'b0, (n_dge ? (n_dtry - {1'b0, r_dv}) : n_dtry)};
                        r_q   <= {r_q[62:0], n_dge};
                        r_y   <= r_y << 1;
                    end
                    ALU_SQRT: begin
                        r_rem <= n_sge ? (n_stry - n_strial) : n_stry;
                        r_q   <= {r_q[62:0], n_sge};
                        r_y   <= r_y << 2;
                    end
                    default: begin
                        r_y <= r_y;
                    end
                endcase
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        unique case (r_op)
            ALU_MUL:  o_res = r_acc;
            ALU_DIV:  o_res = {32'b0, r_q};
            ALU_SQRT: o_res = {64'b0, r_q[31:0]};
            default:  o_res = r_acc;
        endcase
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

### design/pvdw_chk.sv
`default_nettype none
module pvdw_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_dt_valid,
    input wire logic        o_dt_ready,
    input wire logic        o_res_valid,
    input wire logic        i_res_ready,
    input wire logic [31:0] o_pos_x,
    input wire logic [2:0]  o_wall_hit
);
    import pvdw_pkg::*;

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dt_valid && o_dt_ready |=> !o_dt_ready)
        else $error("input taken while a tick is running");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_pos_x))
        else $error("stalled result changed");

    a_hit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_wall_hit <= HIT_LEFT)
        else $error("bad wall code");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result after reset");

endmodule

bind particle_verlet_drag_wall_step_core pvdw_chk u_pvdw_chk (.*);
`default_nettype wire
